// ----- hw/rtl/stu_pkg.sv -----
// ----------------------------------------------------------------------------
// stu_pkg
// Shared types and constants for the source text tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package stu_pkg;

    localparam int POSITION_BITS = 16;
    localparam int LENGTH_BITS   = 8;

    localparam logic [4:0] KIND_END    = 5'd0;
    localparam logic [4:0] KIND_IDENT  = 5'd1;
    localparam logic [4:0] KIND_NUMBER = 5'd2;
    localparam logic [4:0] KIND_FN     = 5'd3;
    localparam logic [4:0] KIND_IF     = 5'd4;
    localparam logic [4:0] KIND_LET    = 5'd5;
    localparam logic [4:0] KIND_ELSE   = 5'd6;
    localparam logic [4:0] KIND_ARROW  = 5'd7;
    localparam logic [4:0] KIND_EQ     = 5'd8;
    localparam logic [4:0] KIND_NE     = 5'd9;
    localparam logic [4:0] KIND_INC    = 5'd10;
    localparam logic [4:0] KIND_DEC    = 5'd11;
    localparam logic [4:0] KIND_LAND   = 5'd12;
    localparam logic [4:0] KIND_LOR    = 5'd13;
    localparam logic [4:0] KIND_LE     = 5'd14;
    localparam logic [4:0] KIND_GE     = 5'd15;
    localparam logic [4:0] KIND_SHR    = 5'd16;
    localparam logic [4:0] KIND_SHL    = 5'd17;
    localparam logic [4:0] KIND_SINGLE = 5'd18;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_input;
    } src_item_t;

    typedef struct packed {
        logic [4:0]               token_kind;
        logic [7:0]               single_char;
        logic [POSITION_BITS-1:0] token_start;
        logic [LENGTH_BITS-1:0]   token_length;
        logic                     last;
    } tok_item_t;

    // up to two tokens produced by one source byte
    typedef struct packed {
        logic [1:0] count;
        tok_item_t  first;
        tok_item_t  second;
    } tok_push_t;

endpackage

`default_nettype wire

// ----- hw/rtl/source_text_tokenizer_unit.sv -----
// ----------------------------------------------------------------------------
// source_text_tokenizer_unit
// Streaming lexer: source bytes in, tokens (kind, start, length) out.
// ----------------------------------------------------------------------------
// Usage:
//   src channel: one source byte or an end marker per transaction
//     (src_valid / src_stall / src_item).
//   tok channel: one token per transaction (tok_valid / tok_stall /
//     tok_item); the last flag marks the final token of a source byte.
//   A byte is decided in the cycle it is accepted; its tokens are written
//   into a four-entry queue register and are offered on tok from there.
//   One byte per cycle is taken while the queue holds at most two tokens,
//   so throughput is one byte per cycle, bounded by the tok port's one
//   token per cycle when bytes end tokens back to back (at most two
//   tokens per byte).
//   While tok is stalled the head token holds and the queue fills; src
//   stalls once fewer than two free entries remain.
//   Reset empties the queue and returns the lexer to idle at position 0;
//   an end marker returns the lexer there after emitting its tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module source_text_tokenizer_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              src_valid,
    output logic                   src_stall,
    input  wire stu_pkg::src_item_t src_item,
    output logic                   tok_valid,
    input  wire logic              tok_stall,
    output stu_pkg::tok_item_t     tok_item
);

    stu_pkg::tok_push_t push;
    logic               room;
    logic               accept;

    assign src_stall = !room;
    assign accept    = src_valid && room;

    stu_lexer u_lexer (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (src_item),
        .push   (push)
    );

    stu_token_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_item  (tok_item)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/stu_lexer.sv -----
// ----------------------------------------------------------------------------
// stu_lexer
// Lexer state and per-byte token decision; yields zero to two tokens per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module stu_lexer (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire stu_pkg::src_item_t item,
    output stu_pkg::tok_push_t     push
);

    localparam int PB = stu_pkg::POSITION_BITS;
    localparam int LB = stu_pkg::LENGTH_BITS;

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_IDENT  = 2'd1;
    localparam logic [1:0] MODE_NUMBER = 2'd2;
    localparam logic [1:0] MODE_OPER   = 2'd3;

    // keyword tracker codes
    localparam logic [3:0] TRK_NONE = 4'd0;
    localparam logic [3:0] TRK_F    = 4'd1;
    localparam logic [3:0] TRK_FN   = 4'd2;
    localparam logic [3:0] TRK_I    = 4'd3;
    localparam logic [3:0] TRK_IF   = 4'd4;
    localparam logic [3:0] TRK_L    = 4'd5;
    localparam logic [3:0] TRK_LE   = 4'd6;
    localparam logic [3:0] TRK_LET  = 4'd7;
    localparam logic [3:0] TRK_E    = 4'd8;
    localparam logic [3:0] TRK_EL   = 4'd9;
    localparam logic [3:0] TRK_ELS  = 4'd10;
    localparam logic [3:0] TRK_ELSE = 4'd11;

    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_T     = 8'h74;

    localparam logic [LB-1:0] LEN_MAX = {LB{1'b1}};
    localparam logic [LB-1:0] LEN_ONE = LB'(1);
    localparam logic [LB-1:0] LEN_TWO = LB'(2);

    localparam logic [4:0] KIND_END = stu_pkg::KIND_END;

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        is_letter = (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= 8'd48 && c <= 8'd57);
    endfunction

    function automatic logic is_op_start(input logic [7:0] c);
        is_op_start = (c == CH_MINUS) || (c == CH_EQ) || (c == CH_BANG) ||
                      (c == CH_PLUS) || (c == CH_AMP) || (c == CH_BAR) ||
                      (c == CH_LT) || (c == CH_GT);
    endfunction

    function automatic logic [4:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
        logic [4:0] k;
        k = KIND_END;
        case (a)
            CH_MINUS: k = (b == CH_GT) ? stu_pkg::KIND_ARROW :
                          (b == CH_MINUS) ? stu_pkg::KIND_DEC : stu_pkg::KIND_END;
            CH_EQ:    k = (b == CH_EQ) ? stu_pkg::KIND_EQ : stu_pkg::KIND_END;
            CH_BANG:  k = (b == CH_EQ) ? stu_pkg::KIND_NE : stu_pkg::KIND_END;
            CH_PLUS:  k = (b == CH_PLUS) ? stu_pkg::KIND_INC : stu_pkg::KIND_END;
            CH_AMP:   k = (b == CH_AMP) ? stu_pkg::KIND_LAND : stu_pkg::KIND_END;
            CH_BAR:   k = (b == CH_BAR) ? stu_pkg::KIND_LOR : stu_pkg::KIND_END;
            CH_LT:    k = (b == CH_EQ) ? stu_pkg::KIND_LE :
                          (b == CH_LT) ? stu_pkg::KIND_SHL : stu_pkg::KIND_END;
            CH_GT:    k = (b == CH_EQ) ? stu_pkg::KIND_GE :
                          (b == CH_GT) ? stu_pkg::KIND_SHR : stu_pkg::KIND_END;
            default:  k = stu_pkg::KIND_END;
        endcase
        pair_kind = k;
    endfunction

    function automatic logic [3:0] track_first(input logic [7:0] c);
        logic [3:0] t;
        case (c)
            CH_F:    t = TRK_F;
            CH_I:    t = TRK_I;
            CH_L:    t = TRK_L;
            CH_E:    t = TRK_E;
            default: t = TRK_NONE;
        endcase
        track_first = t;
    endfunction

    function automatic logic [3:0] track_step(input logic [3:0] t, input logic [7:0] c);
        logic [3:0] r;
        r = TRK_NONE;
        if (t == TRK_F && c == CH_N)        r = TRK_FN;
        else if (t == TRK_I && c == CH_F)   r = TRK_IF;
        else if (t == TRK_L && c == CH_E)   r = TRK_LE;
        else if (t == TRK_LE && c == CH_T)  r = TRK_LET;
        else if (t == TRK_E && c == CH_L)   r = TRK_EL;
        else if (t == TRK_EL && c == CH_S)  r = TRK_ELS;
        else if (t == TRK_ELS && c == CH_E) r = TRK_ELSE;
        track_step = r;
    endfunction

    logic [1:0]    mode_reg,  mode_next;
    logic [7:0]    pend_reg,  pend_next;
    logic [3:0]    track_reg, track_next;
    logic [LB-1:0] len_reg,   len_next;
    logic [PB-1:0] start_reg, start_next;
    logic [PB-1:0] pos_reg,   pos_next;

    stu_pkg::tok_item_t flush_tok;
    stu_pkg::tok_item_t second_tok;
    logic               flush_v;
    logic               second_v;
    logic [7:0]         c;
    logic [4:0]         pk;

    // token that a pending run would produce if it ended now
    always_comb
    begin
        flush_tok             = '0;
        flush_tok.token_start = start_reg;
        flush_tok.token_length = len_reg;
        case (mode_reg)
            MODE_IDENT:
            begin
                case (track_reg)
                    TRK_FN:   flush_tok.token_kind = stu_pkg::KIND_FN;
                    TRK_IF:   flush_tok.token_kind = stu_pkg::KIND_IF;
                    TRK_LET:  flush_tok.token_kind = stu_pkg::KIND_LET;
                    TRK_ELSE: flush_tok.token_kind = stu_pkg::KIND_ELSE;
                    default:  flush_tok.token_kind = stu_pkg::KIND_IDENT;
                endcase
            end
            MODE_NUMBER: flush_tok.token_kind = stu_pkg::KIND_NUMBER;
            MODE_OPER:
            begin
                flush_tok.token_kind   = stu_pkg::KIND_SINGLE;
                flush_tok.single_char  = pend_reg;
                flush_tok.token_length = LEN_ONE;
            end
            default: flush_tok.token_kind = KIND_END;
        endcase
    end

    always_comb
    begin
        c            = item.char_byte;
        pk           = pair_kind(pend_reg, c);
        mode_next    = mode_reg;
        pend_next    = pend_reg;
        track_next   = track_reg;
        len_next     = len_reg;
        start_next   = start_reg;
        pos_next     = pos_reg;
        flush_v      = 1'b0;
        second_v     = 1'b0;
        second_tok   = '0;

        if (accept)
        begin
            if (item.end_of_input)
            begin
                flush_v                 = (mode_reg != MODE_IDLE);
                second_v                = 1'b1;
                second_tok.token_kind   = KIND_END;
                second_tok.token_start  = pos_reg;
                mode_next    = MODE_IDLE;
                pend_next    = '0;
                track_next   = TRK_NONE;
                len_next     = '0;
                start_next   = '0;
                pos_next     = '0;
            end
            else
            begin
                pos_next = pos_reg + PB'(1);
                if (mode_reg == MODE_IDENT && (is_letter(c) || is_digit(c) || c == CH_UNDER))
                begin
                    track_next = track_step(track_reg, c);
                    if (len_reg != LEN_MAX)
                        len_next = len_reg + LEN_ONE;
                end
                else if (mode_reg == MODE_NUMBER && (is_digit(c) || c == CH_UNDER))
                begin
                    if (len_reg != LEN_MAX)
                        len_next = len_reg + LEN_ONE;
                end
                else if (mode_reg == MODE_OPER && pk != KIND_END)
                begin
                    second_v                = 1'b1;
                    second_tok.token_kind   = pk;
                    second_tok.token_start  = start_reg;
                    second_tok.token_length = LEN_TWO;
                    mode_next = MODE_IDLE;
                    pend_next = '0;
                    len_next  = '0;
                end
                else
                begin
                    // close the pending run, then start from this byte
                    flush_v      = (mode_reg != MODE_IDLE);
                    mode_next    = MODE_IDLE;
                    pend_next    = '0;
                    track_next   = TRK_NONE;
                    len_next     = '0;
                    if (!is_space(c))
                    begin
                        start_next = pos_reg;
                        len_next   = LEN_ONE;
                        if (is_letter(c) || c == CH_UNDER)
                        begin
                            mode_next  = MODE_IDENT;
                            track_next = track_first(c);
                        end
                        else if (is_digit(c))
                            mode_next = MODE_NUMBER;
                        else if (is_op_start(c))
                        begin
                            mode_next = MODE_OPER;
                            pend_next = c;
                        end
                        else
                        begin
                            second_v                = 1'b1;
                            second_tok.token_kind   = stu_pkg::KIND_SINGLE;
                            second_tok.single_char  = c;
                            second_tok.token_start  = pos_reg;
                            second_tok.token_length = LEN_ONE;
                            len_next                = '0;
                        end
                    end
                end
            end
        end
    end

    always_comb
    begin
        push = '0;
        if (flush_v)
        begin
            push.count       = second_v ? 2'd2 : 2'd1;
            push.first       = flush_tok;
            push.first.last  = !second_v;
            push.second      = second_tok;
            push.second.last = 1'b1;
        end
        else if (second_v)
        begin
            push.count      = 2'd1;
            push.first      = second_tok;
            push.first.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            pend_reg  <= '0;
            track_reg <= TRK_NONE;
            len_reg   <= '0;
            start_reg <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            pend_reg  <= pend_next;
            track_reg <= track_next;
            len_reg   <= len_next;
            start_reg <= start_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/stu_token_queue.sv -----
// ----------------------------------------------------------------------------
// stu_token_queue
// Four-entry queue: takes up to two tokens per cycle, sends one unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module stu_token_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire stu_pkg::tok_push_t push,
    output logic                   room,
    output logic                   tok_valid,
    input  wire logic              tok_stall,
    output stu_pkg::tok_item_t     tok_item
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    stu_pkg::tok_item_t mem [DEPTH];

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [AW:0]   count_reg, count_next;
    logic          pop;

    // room for a worst-case byte (two tokens)
    assign room      = (count_reg <= (AW+1)'(DEPTH - 2));
    assign tok_valid = (count_reg != '0);
    assign tok_item  = mem[head_reg];
    assign pop       = tok_valid && !tok_stall;

    always_comb
    begin
        head_next  = pop ? head_reg + AW'(1) : head_reg;
        tail_next  = tail_reg + AW'(push.count);
        count_next = count_reg + (AW+1)'(push.count) - (AW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[tail_reg] <= push.first;
        if (push.count == 2'd2)
            mem[tail_reg + AW'(1)] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire
